>>> hw/rtl/klc_pkg.sv
// klc_pkg: shared types, constants and the sine table entry function for the
// lattice coupling stencil. No dependencies.
package klc_pkg;

	localparam int ROW_LIMIT = 4096;
	localparam int COL_LIMIT = 1024;

	localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
	localparam logic [63:0] PI_Q30      = 64'd3373259426;
	localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
	localparam logic [63:0] ONE_Q30     = 64'd1073741824;
	localparam logic signed [30:0] INV_TWO_PI_Q32 = 31'sd683565276;

	localparam logic [1:0] REG_ROWS = 2'd0;
	localparam logic [1:0] REG_COLS = 2'd1;
	localparam logic [1:0] REG_GAIN = 2'd2;
	localparam logic [1:0] REG_MODE = 2'd3;

	localparam logic [3:0] STEP_CENTRE = 4'd0;
	localparam logic [3:0] STEP_UP     = 4'd1;
	localparam logic [3:0] STEP_LEFT   = 4'd2;
	localparam logic [3:0] STEP_RIGHT  = 4'd3;
	localparam logic [3:0] STEP_FEED_R = 4'd4;
	localparam logic [3:0] STEP_DOWN   = 4'd5;
	localparam logic [3:0] STEP_MUL    = 4'd10;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_RUN,
		ST_FIN
	} klc_state_t;

	typedef struct packed {
		logic valid;
		logic en;
	} klc_term_ctl_t;

	// sine in q1.14 of a q30 angle in [0, 2pi]
	function automatic logic signed [15:0] klc_sine_q14(input logic [63:0] ang);
		logic [63:0] a;
		logic [63:0] x2;
		logic [63:0] h;
		logic [63:0] s;
		logic [63:0] q;
		logic neg;
		a = ang;
		neg = 1'b0;
		if (a > PI_Q30) begin
			neg = 1'b1;
			a = a - PI_Q30;
		end
		if (a > PI_Q30) a = PI_Q30;
		if (a > HALF_PI_Q30) a = PI_Q30 - a;
		x2 = (a * a) >> 30;
		h = ONE_Q30;
		h = ONE_Q30 - ((x2 * h) >> 30) / 64'd110;
		h = ONE_Q30 - ((x2 * h) >> 30) / 64'd72;
		h = ONE_Q30 - ((x2 * h) >> 30) / 64'd42;
		h = ONE_Q30 - ((x2 * h) >> 30) / 64'd20;
		h = ONE_Q30 - ((x2 * h) >> 30) / 64'd6;
		s = (a * h) >> 30;
		q = (s + 64'd32768) >> 16;
		if (q > 64'd16384) q = 64'd16384;
		return neg ? -$signed(q[15:0]) : $signed(q[15:0]);
	endfunction

endpackage

>>> hw/rtl/klc_sine_rom.sv
// klc_sine_rom: constant sine table with a registered read port.
// Depends on klc_pkg.
module klc_sine_rom import klc_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic                         clk,
	input  logic [$clog2(DEPTH)-1:0]     addr,
	output logic signed [15:0]           q
);

	logic signed [15:0] rom_c [DEPTH];

	for (genvar i = 0; i < DEPTH; i++) begin : g_rom
		localparam logic [63:0] ANG = (64'(i) * TWO_PI_Q30 + 64'(DEPTH / 2)) / 64'(DEPTH);
		assign rom_c[i] = klc_sine_q14(ANG);
	end

	always_ff @(posedge clk) begin
		q <= rom_c[addr];
	end

endmodule

>>> hw/rtl/klc_term_pipe.sv
// klc_term_pipe: four-stage coupling term unit (difference, turn fraction,
// table index, table read). Depends on klc_pkg and klc_sine_rom.
module klc_term_pipe import klc_pkg::*; #(
	parameter int DEPTH = 1024
) (
	input  logic                clk,
	input  logic                arst_n,
	input  klc_term_ctl_t       ctl,
	input  logic                mode,
	input  logic signed [19:0]  nb,
	input  logic signed [19:0]  centre,
	output logic signed [20:0]  term
);

	localparam int RW = $clog2(DEPTH);
	localparam int KW = RW + 1;

	klc_term_ctl_t ctl_s1, ctl_s2, ctl_s3, ctl_s4;
	logic signed [20:0] d_s1, d_s2, d_s3, d_s4;
	logic [43:0] u_s2;
	logic [RW-1:0] k_s3;
	logic signed [15:0] sin_s4;
	logic signed [50:0] prod;
	logic [39:0] kp;
	logic [KW-1:0] kfull;

	assign prod  = 51'(d_s1) * 51'(INV_TWO_PI_Q32);
	assign kp    = 40'(u_s2[43:20]) * 40'(DEPTH) + 40'(24'h800000);
	assign kfull = kp[24 +: KW];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
			ctl_s2 <= '0;
			ctl_s3 <= '0;
			ctl_s4 <= '0;
		end else begin
			ctl_s1 <= ctl;
			ctl_s2 <= ctl_s1;
			ctl_s3 <= ctl_s2;
			ctl_s4 <= ctl_s3;
		end
	end

	always_ff @(posedge clk) begin
		d_s1 <= 21'(nb) - 21'(centre);
		d_s2 <= d_s1;
		u_s2 <= prod[43:0];
		d_s3 <= d_s2;
		k_s3 <= (kfull == KW'(DEPTH)) ? '0 : kfull[RW-1:0];
		d_s4 <= d_s3;
	end

	klc_sine_rom #(.DEPTH(DEPTH)) u_rom (
		.clk  (clk),
		.addr (k_s3),
		.q    (sin_s4)
	);

	always_comb begin
		if (ctl_s4.valid && ctl_s4.en) begin
			term = mode ? d_s4 : 21'(sin_s4);
		end else begin
			term = '0;
		end
	end

endmodule

>>> hw/rtl/kuramoto_lattice_coupling_stencil_unit.sv
// Top level of the 4-neighbor lattice coupling stencil: config registers,
// phase and accumulator row memories, sequencer. Depends on klc_pkg, klc_term_pipe.
//
// Cells enter in raster order; a cell's updated accumulator leaves when the
// cell below it arrives, and flush beats drain the last row, one cell each.
// A beat that produces a result passes the accept state, eleven sequencer
// steps and the output state. The steps follow from the single read port
// of the phase memory (centre, up, left, right are read one after another)
// and the shared four-stage term unit followed by the gain multiply. Pixel
// beats of the first row and ignored beats stay in the idle state. The
// output register lets the next beat enter while a result waits.
module kuramoto_lattice_coupling_stencil_unit import klc_pkg::*; #(
	parameter int MAX_COLS = 1024,
	parameter int SINE_TABLE_DEPTH = 1024
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [55:0] s_tdata,   // phase[19:0], accum_in[51:20], zero fill
	input  logic [0:0]  s_tuser,   // req_type
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [55:0] m_tdata,   // accum_out[31:0], cell_row[43:32], cell_col[53:44]
	output logic [0:0]  m_tuser,   // saturated
	output logic        m_tlast,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready
);

	localparam int COL_CAP = (MAX_COLS < COL_LIMIT) ? MAX_COLS : COL_LIMIT;
	localparam int AW  = $clog2(2 * MAX_COLS);
	localparam int AAW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;

	logic [12:0] rows_q;
	logic [10:0] cols_q;
	logic signed [15:0] gain_q;
	logic mode_q;

	logic [19:0] pmem [2 * MAX_COLS];
	logic [31:0] amem [MAX_COLS];

	klc_state_t state_q, state_d;
	logic [3:0] step_q;
	logic [9:0] col_q, drain_q;
	logic [11:0] row_q;
	logic loaded_q;

	logic [11:0] er_q;
	logic [9:0] ec_q;
	logic down_en_q, last_q, pix_q;
	logic signed [19:0] phin_q, centre_q, prd_q;
	logic [31:0] accin_q, ard_q;
	logic signed [22:0] sum_q;
	logic signed [38:0] prod_q;

	logic m_tvalid_q, sat_q, mlast_q;
	logic [31:0] oacc_q;
	logic [11:0] orow_q;
	logic [9:0] ocol_q;

	logic [10:0] eff_cols;
	logic [12:0] eff_rows;
	logic acc_in, is_flush, pix_ok, fl_ok, emit_pix, row0_pix;
	logic col_last, row_last, drain_last, fin_go;
	logic up_en, left_en, right_en;
	logic pm_re, pm_we;
	logic [AW-1:0] pm_raddr, pm_waddr;
	logic [19:0] pm_wdata;
	logic [31:0] am_wdata;
	logic [AAW-1:0] am_waddr;
	klc_term_ctl_t tctl;
	logic signed [19:0] tnb;
	logic signed [20:0] term;
	logic signed [38:0] rnd, delta;
	logic signed [39:0] acc_sum;
	logic [31:0] acc_sat;
	logic sat_flag;

	function automatic logic [AW-1:0] paddr_of(input logic bank, input logic [9:0] col);
		return bank ? AW'(MAX_COLS) + AW'(col) : AW'(col);
	endfunction

	// config
	assign pready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= 13'd1;
			cols_q <= 11'd1;
			gain_q <= 16'sd4096;
			mode_q <= 1'b0;
		end else if (psel && penable && pwrite && pready) begin
			case (paddr[3:2])
				REG_ROWS: rows_q <= pwdata[12:0];
				REG_COLS: cols_q <= pwdata[10:0];
				REG_GAIN: gain_q <= pwdata[15:0];
				REG_MODE: mode_q <= pwdata[0];
				default:  ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_ROWS: prdata = 32'(rows_q);
			REG_COLS: prdata = 32'(cols_q);
			REG_GAIN: prdata = 32'(unsigned'(gain_q));
			REG_MODE: prdata = 32'(mode_q);
			default:  prdata = '0;
		endcase
	end

	always_comb begin
		if (cols_q == '0) eff_cols = 11'd1;
		else if (cols_q > 11'(COL_CAP)) eff_cols = 11'(COL_CAP);
		else eff_cols = cols_q;
		if (rows_q == '0) eff_rows = 13'd1;
		else if (rows_q > 13'(ROW_LIMIT)) eff_rows = 13'(ROW_LIMIT);
		else eff_rows = rows_q;
	end

	// beat decode
	assign acc_in     = s_tvalid && s_tready;
	assign is_flush   = s_tuser[0];
	assign pix_ok     = !is_flush && !loaded_q;
	assign fl_ok      = is_flush && loaded_q;
	assign emit_pix   = pix_ok && (row_q != '0);
	assign row0_pix   = pix_ok && (row_q == '0);
	assign col_last   = (11'(col_q) + 11'd1) >= eff_cols;
	assign row_last   = (13'(row_q) + 13'd1) >= eff_rows;
	assign drain_last = (11'(drain_q) + 11'd1) >= eff_cols;

	// sequencer
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		fin_go   = 1'b0;
		case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid && (emit_pix || fl_ok)) state_d = ST_RUN;
			end
			ST_RUN: begin
				if (step_q == STEP_MUL) state_d = ST_FIN;
			end
			ST_FIN: begin
				if (!m_tvalid_q || m_tready) begin
					fin_go  = 1'b1;
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			step_q  <= (state_q == ST_RUN) ? step_q + 4'd1 : '0;
		end
	end

	// positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q    <= '0;
			row_q    <= '0;
			drain_q  <= '0;
			loaded_q <= 1'b0;
		end else if (acc_in) begin
			if (pix_ok) begin
				if (col_last) begin
					col_q <= '0;
					if (row_last) begin
						loaded_q <= 1'b1;
						drain_q  <= '0;
					end else begin
						row_q <= row_q + 12'd1;
					end
				end else begin
					col_q <= col_q + 10'd1;
				end
			end else if (fl_ok) begin
				if (drain_last) begin
					loaded_q <= 1'b0;
					drain_q  <= '0;
					row_q    <= '0;
					col_q    <= '0;
				end else begin
					drain_q <= drain_q + 10'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (acc_in) begin
			phin_q    <= s_tdata[19:0];
			accin_q   <= s_tdata[51:20];
			pix_q     <= pix_ok;
			down_en_q <= pix_ok;
			if (pix_ok) begin
				er_q   <= row_q - 12'd1;
				ec_q   <= col_q;
				last_q <= 1'b0;
			end else begin
				er_q   <= row_q;
				ec_q   <= drain_q;
				last_q <= drain_last;
			end
		end
	end

	assign up_en    = er_q != '0;
	assign left_en  = ec_q != '0;
	assign right_en = (11'(ec_q) + 11'd1) < eff_cols;

	// memories
	always_comb begin
		pm_re    = (state_q == ST_RUN) && (step_q <= STEP_RIGHT);
		case (step_q)
			STEP_CENTRE: pm_raddr = paddr_of(er_q[0], ec_q);
			STEP_UP:     pm_raddr = paddr_of(~er_q[0], ec_q);
			STEP_LEFT:   pm_raddr = paddr_of(er_q[0], ec_q - 10'd1);
			STEP_RIGHT:  pm_raddr = paddr_of(er_q[0], ec_q + 10'd1);
			default:     pm_raddr = paddr_of(er_q[0], ec_q);
		endcase
		if (state_q == ST_IDLE) begin
			pm_we    = acc_in && row0_pix;
			pm_waddr = paddr_of(row_q[0], col_q);
			pm_wdata = s_tdata[19:0];
			am_waddr = AAW'(col_q);
			am_wdata = s_tdata[51:20];
		end else begin
			pm_we    = fin_go && pix_q;
			pm_waddr = paddr_of(~er_q[0], ec_q);
			pm_wdata = phin_q;
			am_waddr = AAW'(ec_q);
			am_wdata = accin_q;
		end
	end

	always_ff @(posedge clk) begin
		if (pm_we) pmem[pm_waddr] <= pm_wdata;
		if (pm_re) prd_q <= pmem[pm_raddr];
	end

	always_ff @(posedge clk) begin
		if (pm_we) amem[am_waddr] <= am_wdata;
		if (state_q == ST_RUN && step_q == STEP_CENTRE) ard_q <= amem[AAW'(ec_q)];
	end

	// term feed and sum
	always_comb begin
		tctl.valid = (state_q == ST_RUN) && (step_q >= STEP_LEFT) && (step_q <= STEP_DOWN);
		tnb = prd_q;
		case (step_q)
			STEP_LEFT:   tctl.en = up_en;
			STEP_RIGHT:  tctl.en = left_en;
			STEP_FEED_R: tctl.en = right_en;
			STEP_DOWN: begin
				tctl.en = down_en_q;
				tnb = phin_q;
			end
			default:     tctl.en = 1'b0;
		endcase
	end

	klc_term_pipe #(.DEPTH(SINE_TABLE_DEPTH)) u_term (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (tctl),
		.mode   (mode_q),
		.nb     (tnb),
		.centre (centre_q),
		.term   (term)
	);

	always_ff @(posedge clk) begin
		if (state_q == ST_RUN && step_q == STEP_UP) centre_q <= prd_q;
		if (state_q == ST_RUN && step_q == STEP_CENTRE) sum_q <= '0;
		else sum_q <= sum_q + 23'(term);
		if (state_q == ST_RUN && step_q == STEP_MUL) prod_q <= 39'(gain_q) * 39'(sum_q);
	end

	// round, add, saturate
	always_comb begin
		rnd = prod_q + (mode_q ? 39'sd2048 : 39'sd8192);
		delta = mode_q ? (rnd >>> 12) : (rnd >>> 14);
		acc_sum = 40'($signed(ard_q)) + 40'(delta);
		sat_flag = 1'b1;
		if (acc_sum > 40'sd2147483647) acc_sat = 32'h7fffffff;
		else if (acc_sum < -40'sd2147483648) acc_sat = 32'h80000000;
		else begin
			acc_sat = acc_sum[31:0];
			sat_flag = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (fin_go) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin_go) begin
			oacc_q  <= acc_sat;
			orow_q  <= er_q;
			ocol_q  <= ec_q;
			sat_q   <= sat_flag;
			mlast_q <= last_q;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {2'b00, ocol_q, orow_q, oacc_q};
	assign m_tuser  = sat_q;
	assign m_tlast  = mlast_q;

`ifndef SYNTHESIS
	a_loaded_col: assert property (@(posedge clk) disable iff (!arst_n)
		loaded_q |-> col_q == '0)
		else $error("column position not cleared with a loaded frame");
	a_step_bound: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ST_RUN |-> step_q <= STEP_MUL)
		else $error("sequencer step overran");
	a_fin_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && m_tvalid && !m_tready) |=> state_q == ST_FIN)
		else $error("result dropped while output stalled");
`endif

endmodule
